### design/hll_pkg.sv
// Shared widths, payload structs and the case codes of the HLL interface flux block.
package hll_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    localparam int SPEED_W = DATA_WIDTH - 1;
    localparam int PROD_W  = 2 * DATA_WIDTH;
    // Widest of a full product and a difference shifted up by the fraction bits.
    localparam int WIDE_W  = (DATA_WIDTH + FRAC_BITS + 1 > PROD_W) ?
                             (DATA_WIDTH + FRAC_BITS + 1) : PROD_W;
    localparam int NUM_W   = WIDE_W + 2;
    localparam int DIVD_W  = NUM_W + 1;
    localparam int DEN_W   = DATA_WIDTH + 2;
    localparam int HEAD_W  = DIVD_W - DATA_WIDTH;
    localparam int REM_W   = DATA_WIDTH + 3;
    localparam int QPROD_W = 2 * DATA_WIDTH + 1;
    localparam int T_W     = WIDE_W + 3;
    localparam int MAG_W   = T_W - FRAC_BITS - 1;

    localparam logic [T_W-1:0] ROUND_ADD = T_W'(1) << FRAC_BITS;
    localparam logic [DATA_WIDTH-1:0] POS_LIMIT = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] NEG_LIMIT = {1'b1, {(DATA_WIDTH - 1){1'b0}}};

    typedef enum logic [1:0] {
        CASE_LEFT  = 2'd0,
        CASE_RIGHT = 2'd1,
        CASE_HLL   = 2'd2
    } case_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] speed_min;
        logic signed [DATA_WIDTH-1:0] speed_max;
        logic signed [DATA_WIDTH-1:0] state_left;
        logic signed [DATA_WIDTH-1:0] state_right;
        logic signed [DATA_WIDTH-1:0] flux_left;
        logic signed [DATA_WIDTH-1:0] flux_right;
    } req_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] interface_flux;
        logic [SPEED_W-1:0]           edge_speed;
        case_t                        case_taken;
        logic                         overflow;
    } rsp_t;

    // Everything an item carries alongside its division.
    typedef struct packed {
        case_t                        kind;
        logic [SPEED_W-1:0]           speed;
        logic signed [DATA_WIDTH-1:0] pass_flux;
        logic signed [DATA_WIDTH:0]   fsum;
        logic signed [DATA_WIDTH:0]   ssum;
        logic signed [PROD_W:0]       psum;
        logic                         q_neg;
        logic                         d_zero;
    } side_t;

endpackage

### design/hll_interface_flux.sv
// Top level of the HLL interface flux pipeline.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_ready    req_t: speeds, states, fluxes
//   rsp      out        rsp_valid / rsp_ready    rsp_t: flux, edge speed, case, overflow
//
// One transaction enters per cycle while req_ready is high. The divider resolves one
// quotient bit per stage and has four stages before it and six after it. Every stage
// holds its own valid bit and loads whenever it is empty or the stage after it moves,
// so bubbles close up under a stall and nothing is lost.
// Reset clears the valid bits only.
module hll_interface_flux
    import hll_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  req_valid,
    output logic  req_ready,
    input  req_t  req,
    output logic  rsp_valid,
    input  logic  rsp_ready,
    output rsp_t  rsp
);

    localparam int W = DATA_WIDTH;

    // ---------------- stage A1: products, sums, case and edge speed
    logic signed [W-1:0] s1, s2;
    logic [W-1:0]        r1, r2, a1, a2, amax;
    logic                n1, n2, z1, z2;
    case_t               kind_next;
    logic [SPEED_W-1:0]  speed_next;

    assign s1 = req.speed_min;
    assign s2 = req.speed_max;
    assign r1 = req.speed_min;
    assign r2 = req.speed_max;

    always_comb
    begin
        n1   = r1[W-1];
        n2   = r2[W-1];
        z1   = (r1 == '0);
        z2   = (r2 == '0);
        a1   = n1 ? -r1 : r1;
        a2   = n2 ? -r2 : r2;
        amax = (a1 > a2) ? a1 : a2;
        speed_next = amax[W-1] ? {SPEED_W{1'b1}} : amax[W-2:0];
        if ((z1 && z2) || (!n1 && !n2 && !z1 && !z2))
        begin
            kind_next = CASE_LEFT;
        end
        else if (n1 && n2)
        begin
            kind_next = CASE_RIGHT;
        end
        else
        begin
            kind_next = CASE_HLL;
        end
    end

    logic                    v_a1_reg;
    logic signed [PROD_W-1:0] p1_a1_reg, p2_a1_reg;
    logic signed [W:0]       fdiff_a1_reg, d_a1_reg;
    side_t                   side_a1_reg;
    side_t                   side_a1_next;
    logic                    en_a1, en_a2, en_a3, en_a4;
    logic                    en_b1, en_b2, en_b3, en_b4, en_b5, en_b6;

    always_comb
    begin
        side_a1_next           = '0;
        side_a1_next.kind      = kind_next;
        side_a1_next.speed     = speed_next;
        side_a1_next.pass_flux = (kind_next == CASE_RIGHT) ? req.flux_right : req.flux_left;
        side_a1_next.fsum      = (W + 1)'(req.flux_left) + (W + 1)'(req.flux_right);
        side_a1_next.ssum      = (W + 1)'(s1) + (W + 1)'(s2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a1_reg <= 1'b0;
        end
        else if (en_a1)
        begin
            v_a1_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a1)
        begin
            p1_a1_reg    <= PROD_W'(s1) * PROD_W'(req.state_left);
            p2_a1_reg    <= PROD_W'(s2) * PROD_W'(req.state_right);
            fdiff_a1_reg <= (W + 1)'(req.flux_right) - (W + 1)'(req.flux_left);
            d_a1_reg     <= (W + 1)'(s1) - (W + 1)'(s2);
            side_a1_reg  <= side_a1_next;
        end
    end

    // ---------------- stage A2: numerator of the star value
    logic              v_a2_reg;
    logic signed [NUM_W-1:0] num_a2_reg;
    logic signed [W:0] d_a2_reg;
    side_t             side_a2_reg;
    side_t             side_a2_next;

    always_comb
    begin
        side_a2_next      = side_a1_reg;
        side_a2_next.psum = (PROD_W + 1)'(p1_a1_reg) + (PROD_W + 1)'(p2_a1_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a2_reg <= 1'b0;
        end
        else if (en_a2)
        begin
            v_a2_reg <= v_a1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a2)
        begin
            num_a2_reg       <= (NUM_W'(fdiff_a1_reg) <<< FRAC_BITS) + NUM_W'(p1_a1_reg)
                                - NUM_W'(p2_a1_reg);
            d_a2_reg         <= d_a1_reg;
            side_a2_reg      <= side_a2_next;
        end
    end

    // ---------------- stage A3: magnitudes and quotient sign
    logic              v_a3_reg;
    logic [NUM_W-1:0]  absn_a3_reg;
    logic [W:0]        absd_a3_reg;
    side_t             side_a3_reg;
    side_t             side_a3_next;
    logic [W:0]        d_bits;

    assign d_bits = d_a2_reg;

    always_comb
    begin
        side_a3_next        = side_a2_reg;
        side_a3_next.q_neg  = num_a2_reg[NUM_W-1] ^ d_bits[W];
        side_a3_next.d_zero = (d_bits == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a3_reg <= 1'b0;
        end
        else if (en_a3)
        begin
            v_a3_reg <= v_a2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_a3)
        begin
            absn_a3_reg        <= num_a2_reg[NUM_W-1] ? NUM_W'(-num_a2_reg)
                                                       : NUM_W'(num_a2_reg);
            absd_a3_reg        <= d_bits[W] ? -d_bits : d_bits;
            side_a3_reg        <= side_a3_next;
        end
    end

    // ---------------- stage A4: rounded dividend and divisor
    logic              v_a4_reg;
    logic [DIVD_W-1:0] dvd_a4_reg;
    logic [DEN_W-1:0]  den_a4_reg;
    side_t             side_a4_reg;
    logic              div_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a4_reg <= 1'b0;
        end
        else if (en_a4)
        begin
            v_a4_reg <= v_a3_reg;
        end
    end

    // Rounding to nearest, ties away from zero: (2|n| + |d|) / (2|d|).
    always_ff @(posedge clk)
    begin
        if (en_a4)
        begin
            dvd_a4_reg  <= DIVD_W'({absn_a3_reg, 1'b0}) + DIVD_W'(absd_a3_reg);
            den_a4_reg  <= {absd_a3_reg, 1'b0};
            side_a4_reg <= side_a3_reg;
        end
    end

    // ---------------- divider
    logic            div_valid;
    logic [W-1:0]    div_q;
    logic            div_big;
    side_t           div_side;

    hll_div_pipe u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v_a4_reg),
        .up_ready (div_ready),
        .dividend (dvd_a4_reg),
        .divisor  (den_a4_reg),
        .up_side  (side_a4_reg),
        .dn_valid (div_valid),
        .dn_ready (en_b1),
        .quotient (div_q),
        .too_big  (div_big),
        .dn_side  (div_side)
    );

    // ---------------- stage B1: signed, saturated star value
    logic               v_b1_reg;
    logic signed [W-1:0] qs_b1_reg;
    logic               qov_b1_reg;
    side_t              side_b1_reg;
    logic [W-1:0]       qs_next;
    logic               qov_next;
    logic               q_over;

    always_comb
    begin
        if (div_side.q_neg)
        begin
            q_over = div_big || (div_q[W-1] && (div_q[W-2:0] != '0));
        end
        else
        begin
            q_over = div_big || div_q[W-1];
        end
        if (div_side.d_zero)
        begin
            qs_next  = '0;
            qov_next = 1'b0;
        end
        else if (q_over)
        begin
            qs_next  = div_side.q_neg ? NEG_LIMIT : POS_LIMIT;
            qov_next = 1'b1;
        end
        else
        begin
            qs_next  = div_side.q_neg ? -div_q : div_q;
            qov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b1_reg <= 1'b0;
        end
        else if (en_b1)
        begin
            v_b1_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b1)
        begin
            qs_b1_reg   <= qs_next;
            qov_b1_reg  <= qov_next;
            side_b1_reg <= div_side;
        end
    end

    // ---------------- stage B2: (s1 + s2) * Q*
    logic                     v_b2_reg;
    logic signed [QPROD_W-1:0] prod_b2_reg;
    logic                     qov_b2_reg;
    side_t                    side_b2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b2_reg <= 1'b0;
        end
        else if (en_b2)
        begin
            v_b2_reg <= v_b1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b2)
        begin
            prod_b2_reg <= QPROD_W'(side_b1_reg.ssum) * QPROD_W'(qs_b1_reg);
            qov_b2_reg  <= qov_b1_reg;
            side_b2_reg <= side_b1_reg;
        end
    end

    // ---------------- stage B3: doubled flux before halving
    logic                 v_b3_reg;
    logic signed [T_W-1:0] t_b3_reg;
    logic                 qov_b3_reg;
    side_t                side_b3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b3_reg <= 1'b0;
        end
        else if (en_b3)
        begin
            v_b3_reg <= v_b2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b3)
        begin
            t_b3_reg    <= (T_W'(side_b2_reg.fsum) <<< FRAC_BITS) + T_W'(prod_b2_reg)
                           - T_W'(side_b2_reg.psum);
            qov_b3_reg  <= qov_b2_reg;
            side_b3_reg <= side_b2_reg;
        end
    end

    // ---------------- stage B4: magnitude of the doubled flux
    logic           v_b4_reg;
    logic [T_W-1:0] abst_b4_reg;
    logic           tneg_b4_reg;
    logic           qov_b4_reg;
    side_t          side_b4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b4_reg <= 1'b0;
        end
        else if (en_b4)
        begin
            v_b4_reg <= v_b3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b4)
        begin
            abst_b4_reg <= t_b3_reg[T_W-1] ? T_W'(-t_b3_reg) : T_W'(t_b3_reg);
            tneg_b4_reg <= t_b3_reg[T_W-1];
            qov_b4_reg  <= qov_b3_reg;
            side_b4_reg <= side_b3_reg;
        end
    end

    // ---------------- stage B5: halve and drop the extra fraction bits, rounded
    logic             v_b5_reg;
    logic [MAG_W-1:0] mag_b5_reg;
    logic             tneg_b5_reg;
    logic             qov_b5_reg;
    side_t            side_b5_reg;
    logic [T_W-1:0]   rounded;

    assign rounded = abst_b4_reg + ROUND_ADD;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b5_reg <= 1'b0;
        end
        else if (en_b5)
        begin
            v_b5_reg <= v_b4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b5)
        begin
            mag_b5_reg  <= rounded[T_W-1:FRAC_BITS+1];
            tneg_b5_reg <= tneg_b4_reg;
            qov_b5_reg  <= qov_b4_reg;
            side_b5_reg <= side_b4_reg;
        end
    end

    // ---------------- stage B6: saturate, select the case, output register
    logic   v_b6_reg;
    rsp_t   rsp_reg;
    rsp_t   rsp_next;
    logic   f_over;

    always_comb
    begin
        if (tneg_b5_reg)
        begin
            f_over = (mag_b5_reg[MAG_W-1:W] != '0)
                     || (mag_b5_reg[W-1] && (mag_b5_reg[W-2:0] != '0));
        end
        else
        begin
            f_over = (mag_b5_reg[MAG_W-1:W-1] != '0);
        end
        rsp_next            = '0;
        rsp_next.edge_speed = side_b5_reg.speed;
        rsp_next.case_taken = side_b5_reg.kind;
        if (side_b5_reg.kind == CASE_HLL)
        begin
            if (f_over)
            begin
                rsp_next.interface_flux = tneg_b5_reg ? NEG_LIMIT : POS_LIMIT;
            end
            else
            begin
                rsp_next.interface_flux = tneg_b5_reg ? -mag_b5_reg[W-1:0]
                                                      : mag_b5_reg[W-1:0];
            end
            rsp_next.overflow = f_over || qov_b5_reg;
        end
        else
        begin
            rsp_next.interface_flux = side_b5_reg.pass_flux;
            rsp_next.overflow       = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_b6_reg <= 1'b0;
        end
        else if (en_b6)
        begin
            v_b6_reg <= v_b5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b6)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // A stage loads when it is empty or when the stage after it moves.
    assign en_b6 = !v_b6_reg || rsp_ready;
    assign en_b5 = !v_b5_reg || en_b6;
    assign en_b4 = !v_b4_reg || en_b5;
    assign en_b3 = !v_b3_reg || en_b4;
    assign en_b2 = !v_b2_reg || en_b3;
    assign en_b1 = !v_b1_reg || en_b2;
    assign en_a4 = !v_a4_reg || div_ready;
    assign en_a3 = !v_a3_reg || en_a4;
    assign en_a2 = !v_a2_reg || en_a3;
    assign en_a1 = !v_a1_reg || en_a2;

    assign req_ready = en_a1;
    assign rsp_valid = v_b6_reg;
    assign rsp       = rsp_reg;

endmodule

### design/hll_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband that travels along.
module hll_div_pipe
    import hll_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  up_valid,
    output logic                  up_ready,
    input  logic [DIVD_W-1:0]     dividend,
    input  logic [DEN_W-1:0]      divisor,
    input  side_t                 up_side,
    output logic                  dn_valid,
    input  logic                  dn_ready,
    output logic [DATA_WIDTH-1:0] quotient,
    output logic                  too_big,
    output side_t                 dn_side
);

    localparam int STAGES = DATA_WIDTH;

    logic                  v_reg    [0:STAGES];
    logic [REM_W-1:0]      rem_reg  [0:STAGES];
    logic [DATA_WIDTH-1:0] lq_reg   [0:STAGES];
    logic [DEN_W-1:0]      den_reg  [0:STAGES];
    logic                  ovf_reg  [0:STAGES];
    side_t                 side_reg [0:STAGES];
    logic                  en       [0:STAGES];

    assign en[STAGES] = !v_reg[STAGES] || dn_ready;

    genvar k;
    generate
        for (k = 0; k < STAGES; k++) begin : g_en
            assign en[k] = !v_reg[k] || en[k + 1];
        end
    endgenerate

    // Head stage: a quotient that needs more than DATA_WIDTH bits is caught here.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            v_reg[0] <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            ovf_reg[0]  <= dividend[DIVD_W-1:DATA_WIDTH] >= HEAD_W'(divisor);
            rem_reg[0]  <= REM_W'(dividend[DIVD_W-1:DATA_WIDTH]);
            lq_reg[0]   <= dividend[DATA_WIDTH-1:0];
            den_reg[0]  <= divisor;
            side_reg[0] <= up_side;
        end
    end

    generate
        for (k = 1; k <= STAGES; k++) begin : g_bit
            logic [REM_W-1:0] trial;
            logic [REM_W-1:0] rem_next;
            logic             ge;

            // The dividend bits shift out of the top of lq as quotient bits shift in below.
            always_comb
            begin
                trial    = {rem_reg[k - 1][REM_W-2:0], lq_reg[k - 1][DATA_WIDTH-1]};
                ge       = trial >= REM_W'(den_reg[k - 1]);
                rem_next = ge ? (trial - REM_W'(den_reg[k - 1])) : trial;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[k] <= 1'b0;
                end
                else if (en[k])
                begin
                    v_reg[k] <= v_reg[k - 1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k]  <= rem_next;
                    lq_reg[k]   <= {lq_reg[k - 1][DATA_WIDTH-2:0], ge};
                    den_reg[k]  <= den_reg[k - 1];
                    ovf_reg[k]  <= ovf_reg[k - 1];
                    side_reg[k] <= side_reg[k - 1];
                end
            end
        end
    endgenerate

    assign up_ready = en[0];
    assign dn_valid = v_reg[STAGES];
    assign quotient = lq_reg[STAGES];
    assign too_big  = ovf_reg[STAGES];
    assign dn_side  = side_reg[STAGES];

endmodule

### sim/hll_flux_checker.sv
// Checker that predicts every HLL flux transaction and compares the block's results with it.
module hll_flux_checker
    import hll_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   pending
);

    // Wide enough for every product and sum of the flux formula without loss.
    localparam int ACC_W = 128;
    localparam logic signed [ACC_W-1:0] WORD_HI = ACC_W'(POS_LIMIT);
    localparam logic signed [ACC_W-1:0] WORD_LO = ACC_W'($signed(NEG_LIMIT));

    rsp_t flux_due[$];
    int   fail_count = 0;

    // Signed quotient rounded to nearest with ties away from zero; a zero divisor gives zero.
    function automatic logic signed [ACC_W-1:0] div_round_away(
        input logic signed [ACC_W-1:0] n,
        input logic signed [ACC_W-1:0] d
    );
        logic [ACC_W-1:0] an;
        logic [ACC_W-1:0] ad;
        logic [ACC_W-1:0] q;
        if (d == 0)
        begin
            div_round_away = '0;
        end
        else
        begin
            an = (n < 0) ? -n : n;
            ad = (d < 0) ? -d : d;
            q  = (2 * an + ad) / (2 * ad);
            div_round_away = ((n < 0) != (d < 0)) ? -q : q;
        end
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] clamp_word(
        input  logic signed [ACC_W-1:0] a,
        output logic                    hit
    );
        if (a > WORD_HI)
        begin
            hit        = 1'b1;
            clamp_word = POS_LIMIT;
        end
        else if (a < WORD_LO)
        begin
            hit        = 1'b1;
            clamp_word = NEG_LIMIT;
        end
        else
        begin
            hit        = 1'b0;
            clamp_word = a[DATA_WIDTH-1:0];
        end
    endfunction

    function automatic rsp_t hll_flux_of(input req_t item);
        logic signed [ACC_W-1:0] s1;
        logic signed [ACC_W-1:0] s2;
        logic signed [ACC_W-1:0] ql;
        logic signed [ACC_W-1:0] qr;
        logic signed [ACC_W-1:0] fl;
        logic signed [ACC_W-1:0] fr;
        logic signed [ACC_W-1:0] p1;
        logic signed [ACC_W-1:0] p2;
        logic signed [ACC_W-1:0] num;
        logic signed [ACC_W-1:0] star;
        logic signed [ACC_W-1:0] t;
        logic [ACC_W-1:0]        a1;
        logic [ACC_W-1:0]        a2;
        logic [ACC_W-1:0]        fastest;
        logic                    sat_q;
        logic                    sat_f;
        rsp_t                    res;
        s1 = ACC_W'(item.speed_min);
        s2 = ACC_W'(item.speed_max);
        ql = ACC_W'(item.state_left);
        qr = ACC_W'(item.state_right);
        fl = ACC_W'(item.flux_left);
        fr = ACC_W'(item.flux_right);

        // The magnitude of the most negative speed is one past the largest edge speed.
        a1 = (s1 < 0) ? -s1 : s1;
        a2 = (s2 < 0) ? -s2 : s2;
        fastest = (a1 > a2) ? a1 : a2;
        if (fastest > WORD_HI)
            fastest = WORD_HI;
        res.edge_speed = fastest[SPEED_W-1:0];

        if ((s1 == 0 && s2 == 0) || (s1 > 0 && s2 > 0))
        begin
            res.case_taken     = CASE_LEFT;
            res.interface_flux = item.flux_left;
            res.overflow       = 1'b0;
        end
        else if (s1 < 0 && s2 < 0)
        begin
            res.case_taken     = CASE_RIGHT;
            res.interface_flux = item.flux_right;
            res.overflow       = 1'b0;
        end
        else
        begin
            p1   = s1 * ql;
            p2   = s2 * qr;
            num  = ((fr - fl) <<< FRAC_BITS) + p1 - p2;
            star = ACC_W'(clamp_word(div_round_away(num, s1 - s2), sat_q));
            t    = ((fl + fr) <<< FRAC_BITS) + (s1 + s2) * star - p1 - p2;
            // Halving and dropping the extra fraction bits of the products in one rounding.
            res.interface_flux = clamp_word(div_round_away(t, ACC_W'(1) <<< (FRAC_BITS + 1)),
                                            sat_f);
            res.case_taken     = CASE_HLL;
            res.overflow       = sat_q | sat_f;
        end
        return res;
    endfunction

    always @(posedge clk)
    begin : watch_channels
        rsp_t due;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                flux_due.push_back(hll_flux_of(req));
            if (rsp_valid && rsp_ready)
            begin
                if (flux_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("flux check: unexpected result flux %0d speed %0d case %0d ovf %0d",
                                 rsp.interface_flux, rsp.edge_speed, rsp.case_taken,
                                 rsp.overflow);
                end
                else
                begin
                    due = flux_due.pop_front();
                    if (rsp.interface_flux !== due.interface_flux ||
                        rsp.edge_speed !== due.edge_speed ||
                        rsp.case_taken !== due.case_taken ||
                        rsp.overflow !== due.overflow)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                        begin
                            $display("flux check: expected flux %0d speed %0d case %0d ovf %0d",
                                     due.interface_flux, due.edge_speed, due.case_taken,
                                     due.overflow);
                            $display("flux check:   actual flux %0d speed %0d case %0d ovf %0d",
                                     rsp.interface_flux, rsp.edge_speed, rsp.case_taken,
                                     rsp.overflow);
                        end
                    end
                end
            end
            mismatches <= fail_count;
            pending    <= flux_due.size();
        end
    end

endmodule

### sim/tb_hll_interface_flux.sv
// Testbench top for the HLL interface flux block: clock, reset, stimulus and verdict.
module tb_hll_interface_flux;
    import hll_pkg::*;

    localparam int LATENCY     = DATA_WIDTH + 11;
    localparam int PHASE_TXNS  = 580;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam logic signed [DATA_WIDTH-1:0] ONE = DATA_WIDTH'(1) << FRAC_BITS;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;
    int   mismatches;
    int   pending;
    int   send_idle_pct = 25;
    int   recv_idle_pct = 61;
    int   hold_asks     = 0;
    int   hold_done     = 0;
    int   idle_cycles   = 0;

    hll_interface_flux uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    hll_flux_checker flux_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_ready  (rsp_ready),
        .rsp        (rsp),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Half extremes and small magnitudes, so that saturation and rounding are hit often.
    function automatic logic signed [DATA_WIDTH-1:0] random_word();
        logic signed [DATA_WIDTH-1:0] w;
        case ($urandom_range(9))
            0:       w = '0;
            1:       w = POS_LIMIT;
            2:       w = NEG_LIMIT;
            3:       w = $urandom_range(4 << FRAC_BITS);
            4:       w = $urandom_range(3);
            default: w = $urandom;
        endcase
        if ($urandom_range(1))
            w = -w;
        return w;
    endfunction

    function automatic req_t random_item();
        req_t                         item;
        logic signed [DATA_WIDTH-1:0] a;
        logic signed [DATA_WIDTH-1:0] b;
        logic signed [DATA_WIDTH-1:0] swap;
        a = random_word();
        b = random_word();
        if ($urandom_range(9) < 6)
        begin
            // Waves leaving the interface in both directions, which is where the average is taken.
            if (a > 0)
                a = -a;
            if (b < 0)
                b = -b;
            if ($urandom_range(7) == 0)
            begin
                swap = a;
                a    = b;
                b    = swap;
            end
        end
        item.speed_min   = a;
        item.speed_max   = b;
        item.state_left  = random_word();
        item.state_right = random_word();
        item.flux_left   = random_word();
        item.flux_right  = random_word();
        return item;
    endfunction

    task automatic send_txn(input req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic signed [DATA_WIDTH-1:0] s1, s2, ql, qr, fl, fr);
        req_t item;
        item.speed_min   = s1;
        item.speed_max   = s2;
        item.state_left  = ql;
        item.state_right = qr;
        item.flux_left   = fl;
        item.flux_right  = fr;
        send_txn(item);
    endtask

    // The receiver counts its own long hold-off whenever the stimulus asks for one.
    initial
    begin : drive_ready
        int held;
        forever
        begin
            @(posedge clk);
            if (hold_done != hold_asks)
            begin
                hold_done = hold_asks;
                rsp_ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            else
                rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Both speeds zero, both positive, both negative.
        send_fields(0, 0, ONE, -ONE, 123, 456);
        send_fields(ONE, 2 * ONE, 5 * ONE, 7 * ONE, -3 * ONE, 9 * ONE);
        send_fields(-ONE, -3 * ONE, 5 * ONE, 7 * ONE, -3 * ONE, 9 * ONE);
        // One speed zero and the other of either sign, in either position.
        send_fields(0, ONE, 2 * ONE, ONE, ONE, -ONE);
        send_fields(-ONE, 0, 2 * ONE, ONE, ONE, -ONE);
        send_fields(ONE, 0, 2 * ONE, ONE, ONE, -ONE);
        send_fields(0, -ONE, 2 * ONE, ONE, ONE, -ONE);
        // Speeds in reverse order.
        send_fields(2 * ONE, -ONE, 3 * ONE, -ONE, ONE, 4 * ONE);
        // Most negative speeds saturate the edge speed.
        send_fields(NEG_LIMIT, NEG_LIMIT, 0, 0, POS_LIMIT, NEG_LIMIT);
        send_fields(NEG_LIMIT, POS_LIMIT, POS_LIMIT, NEG_LIMIT, NEG_LIMIT, POS_LIMIT);
        send_fields(NEG_LIMIT, POS_LIMIT, NEG_LIMIT, POS_LIMIT, POS_LIMIT, NEG_LIMIT);
        // Exact halves in the star value round away from zero.
        send_fields(-1, 1, 1, 0, 0, 0);
        send_fields(-1, 1, -1, 0, 0, 0);
        // Tiny denominators against large numerators saturate the star value; then wide operands and a zero numerator.
        send_fields(-1, 0, 0, 0, NEG_LIMIT, POS_LIMIT);
        send_fields(0, 1, 0, 0, POS_LIMIT, NEG_LIMIT);
        send_fields(-1, POS_LIMIT, NEG_LIMIT, POS_LIMIT, POS_LIMIT, POS_LIMIT);
        send_fields(-ONE, ONE, 0, 0, 0, 0);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 61 : 0;
            recv_idle_pct <= (phase == 0) ? 61 : (phase == 1) ? 25 : 0;
            // In the last phase the receiver first stops long enough for the pipeline to fill.
            if (phase == 2)
                hold_asks <= hold_asks + 1;
            repeat (PHASE_TXNS) send_txn(random_item());
            req_valid <= 1'b0;
            @(posedge clk);
            while (pending != 0)
                @(posedge clk);
        end

        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### hll_interface_flux.f
design/hll_pkg.sv
design/hll_div_pipe.sv
design/hll_interface_flux.sv
sim/hll_flux_checker.sv
sim/tb_hll_interface_flux.sv
